// ===== src/trv_pkg.sv =====
// ----------------------------------------------------------------------------
// trv_pkg
// Shared types and constants for the trace record varint encoder.
// ----------------------------------------------------------------------------
package trv_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam logic [6:0] GROUP_MASK = 7'h7F;
  localparam int         GROUP_BITS = 7;

  // Field order of one encoded record
  localparam logic [2:0] FLD_KIND   = 3'd0;
  localparam logic [2:0] FLD_SOURCE = 3'd1;
  localparam logic [2:0] FLD_DELTA  = 3'd2;
  localparam logic [2:0] FLD_LOOP   = 3'd3;
  localparam logic [2:0] FLD_LOCAL  = 3'd4;
  localparam logic [2:0] FLD_GEN    = 3'd5;
  localparam logic [2:0] FLD_DETAIL = 3'd6;

  typedef struct packed {
    logic [7:0]  event_kind;
    logic [7:0]  event_source;
    logic [63:0] delta;
    logic [15:0] loop_id;
    logic [31:0] proc_id;
    logic [15:0] generation;
    logic [63:0] detail_word;
  } record_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== src/trv_front.sv =====
// ----------------------------------------------------------------------------
// trv_front
// Accepts trace records, forms the timestamp delta and queues the record.
// ----------------------------------------------------------------------------
module trv_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  first_record,
  input  logic [7:0]            event_kind,
  input  logic [7:0]            event_source,
  input  logic [63:0]           timestamp_ns,
  input  logic [15:0]           loop_id,
  input  logic [31:0]           proc_id,
  input  logic [15:0]           generation,
  input  logic [63:0]           detail_word,
  input  trv_pkg::queue_status_t q_status,
  output logic                  q_push,
  output trv_pkg::record_t      q_entry
);

  logic [63:0] previous_timestamp;
  logic [64:0] diff;

  assign q_push = push && !q_status.full;
  assign diff   = {1'b0, timestamp_ns} - {1'b0, previous_timestamp};

  always_comb begin
    q_entry.event_kind   = event_kind;
    q_entry.event_source = event_source;
    q_entry.loop_id      = loop_id;
    q_entry.proc_id      = proc_id;
    q_entry.generation   = generation;
    q_entry.detail_word  = detail_word;
    // clamp on first record or backward time
    if (first_record || diff[64]) begin
      q_entry.delta = 64'd0;
    end else begin
      q_entry.delta = diff[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_timestamp <= 64'd0;
    end else if (q_push) begin
      previous_timestamp <= timestamp_ns;
    end
  end

endmodule

// ===== src/trv_queue.sv =====
// ----------------------------------------------------------------------------
// trv_queue
// Short record queue between the front and the byte serializer.
// ----------------------------------------------------------------------------
module trv_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  trv_pkg::record_t       wr_data,
  input  logic                   rd_en,
  output trv_pkg::record_t       head,
  output trv_pkg::queue_status_t status
);

  trv_pkg::record_t                mem [trv_pkg::QUEUE_DEPTH];
  logic [trv_pkg::QPTR_W-1:0]      wr_ptr;
  logic [trv_pkg::QPTR_W-1:0]      rd_ptr;
  logic [trv_pkg::QPTR_W:0]        count;
  logic                            do_wr;
  logic                            do_rd;

  assign status.full  = (count == (trv_pkg::QPTR_W+1)'(trv_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_wr        = wr_en && !status.full;
  assign do_rd        = rd_en && !status.empty;
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/trv_back.sv =====
// ----------------------------------------------------------------------------
// trv_back
// Serializes the head record into bytes, one per cycle unless output is held.
// ----------------------------------------------------------------------------
module trv_back (
  input  logic                   clk,
  input  logic                   rst,
  input  trv_pkg::record_t       head,
  input  trv_pkg::queue_status_t q_status,
  output logic                   q_pop,
  input  logic                   pop,
  output logic                   empty,
  output logic [7:0]             out_byte,
  output logic [0:0]             last_byte
);

  logic        busy;
  logic        busy_next;
  logic [2:0]  field;
  logic [2:0]  field_next;
  logic [63:0] value;
  logic [63:0] value_next;
  logic        out_valid;
  logic        out_valid_next;
  logic [7:0]  out_byte_next;
  logic        last_next;
  logic        emit_ok;
  logic        more;
  logic        field_done;

  function automatic logic [63:0] field_value(trv_pkg::record_t r, logic [2:0] f);
    logic [63:0] v;
    case (f)
      trv_pkg::FLD_KIND:   v = {56'd0, r.event_kind};
      trv_pkg::FLD_SOURCE: v = {56'd0, r.event_source};
      trv_pkg::FLD_DELTA:  v = r.delta;
      trv_pkg::FLD_LOOP:   v = {48'd0, r.loop_id};
      trv_pkg::FLD_LOCAL:  v = {32'd0, r.proc_id};
      trv_pkg::FLD_GEN:    v = {48'd0, r.generation};
      trv_pkg::FLD_DETAIL: v = r.detail_word;
      default:             v = 64'd0;
    endcase
    return v;
  endfunction

  assign empty   = !out_valid;
  assign emit_ok = !out_valid || pop;
  assign more    = |value[63:trv_pkg::GROUP_BITS];

  always_comb begin
    busy_next      = busy;
    field_next     = field;
    value_next     = value;
    out_valid_next = out_valid && !pop;
    out_byte_next  = out_byte;
    last_next      = last_byte[0];
    q_pop          = 1'b0;
    field_done     = 1'b0;
    if (!busy) begin
      if (!q_status.empty) begin
        busy_next  = 1'b1;
        field_next = trv_pkg::FLD_KIND;
        value_next = field_value(head, trv_pkg::FLD_KIND);
      end
    end else if (emit_ok) begin
      out_valid_next = 1'b1;
      last_next      = 1'b0;
      if (field == trv_pkg::FLD_KIND || field == trv_pkg::FLD_SOURCE) begin
        out_byte_next = value[7:0];
        field_done    = 1'b1;
      end else begin
        out_byte_next = {more, value[6:0] & trv_pkg::GROUP_MASK};
        field_done    = !more;
      end
      if (!field_done) begin
        value_next = value >> trv_pkg::GROUP_BITS;
      end else if (field == trv_pkg::FLD_DETAIL) begin
        last_next = 1'b1;
        busy_next = 1'b0;
        q_pop     = 1'b1;
      end else begin
        field_next = field + 3'd1;
        value_next = field_value(head, field + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      field     <= trv_pkg::FLD_KIND;
      out_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      field     <= field_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value        <= value_next;
    out_byte     <= out_byte_next;
    last_byte[0] <= last_next;
  end

endmodule

// ===== src/trace_record_varint_encoder_core.sv =====
// ----------------------------------------------------------------------------
// trace_record_varint_encoder_core
// Encodes trace records into kind, source and LEB128 varint bytes.
// ----------------------------------------------------------------------------
// A record is taken whenever full is low; it yields 7 to 33 bytes, kind and
// source first, then LEB128 varints of the timestamp delta, loop_id,
// proc_id, generation and detail_word, with last_byte set on the final one.
// The serializer emits one byte per cycle unless the output byte is held, and
// loads each record in a step of its own before its first byte; a two-entry
// queue ahead of it takes new records while it works.
module trace_record_varint_encoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        first_record,
  input  logic [7:0]  event_kind,
  input  logic [7:0]  event_source,
  input  logic [63:0] timestamp_ns,
  input  logic [15:0] loop_id,
  input  logic [31:0] proc_id,
  input  logic [15:0] generation,
  input  logic [63:0] detail_word,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last_byte
);

  trv_pkg::queue_status_t q_status;
  trv_pkg::record_t       q_entry;
  trv_pkg::record_t       q_head;
  logic                   q_push;
  logic                   q_pop;

  assign full = q_status.full;

  trv_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .first_record (first_record),
    .event_kind   (event_kind),
    .event_source (event_source),
    .timestamp_ns (timestamp_ns),
    .loop_id      (loop_id),
    .proc_id      (proc_id),
    .generation   (generation),
    .detail_word  (detail_word),
    .q_status     (q_status),
    .q_push       (q_push),
    .q_entry      (q_entry)
  );

  trv_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_entry),
    .rd_en   (q_pop),
    .head    (q_head),
    .status  (q_status)
  );

  trv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the trace record varint encoder core.
// ----------------------------------------------------------------------------
// Records go in through the push/full side and encoded bytes come out through
// the empty/pop side, with random idling on both. Every accepted record is
// encoded in the bench (kind, source, then LEB128 groups of the clamped
// timestamp delta, loop id, local id, generation and detail), and each popped
// byte is checked against the oldest predicted one. Directed records cover
// the field extremes, first records, time running backward and the varint
// group boundaries. A long consumer stall backs the core up into full.
// Random records make up the rest of the run.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 300000;
  localparam int IDLE_PCT    = 20;

  typedef struct packed {
    logic        first;
    logic [7:0]  kind;
    logic [7:0]  source;
    logic [63:0] stamp;
    logic [15:0] loop_val;
    logic [31:0] lid;
    logic [15:0] gen;
    logic [63:0] detail;
  } trace_rec_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } enc_byte_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        push;
  logic        full;
  logic        first_record;
  logic [7:0]  event_kind;
  logic [7:0]  event_source;
  logic [63:0] timestamp_ns;
  logic [15:0] loop_id;
  logic [31:0] proc_id;
  logic [15:0] generation;
  logic [63:0] detail_word;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic        last_byte;

  enc_byte_t   expected_bytes[$];
  logic [63:0] prev_stamp;
  logic [63:0] last_sent_stamp;
  bit          idle_enable;
  int          rx_hold_request;
  int          error_count;
  int          byte_count;
  int          cycle_count;

  trace_record_varint_encoder_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .first_record (first_record),
    .event_kind   (event_kind),
    .event_source (event_source),
    .timestamp_ns (timestamp_ns),
    .loop_id      (loop_id),
    .proc_id      (proc_id),
    .generation   (generation),
    .detail_word  (detail_word),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .last_byte    (last_byte)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t byte %0d: %s", $realtime, byte_count, msg);
    error_count++;
  endtask

  task automatic append_leb128(input logic [63:0] v);
    enc_byte_t b;
    do begin
      b.value = {1'b0, v[6:0]};
      b.last  = 1'b0;
      v = v >> 7;
      if (v != 64'd0) b.value[7] = 1'b1;
      expected_bytes.push_back(b);
    end while (v != 64'd0);
  endtask

  task automatic encode_record(input trace_rec_t r);
    logic [63:0] delta;
    enc_byte_t   b;
    if (r.first || r.stamp < prev_stamp) delta = 64'd0;
    else delta = r.stamp - prev_stamp;
    prev_stamp = r.stamp;
    b.last  = 1'b0;
    b.value = r.kind;
    expected_bytes.push_back(b);
    b.value = r.source;
    expected_bytes.push_back(b);
    append_leb128(delta);
    append_leb128({48'd0, r.loop_val});
    append_leb128({32'd0, r.lid});
    append_leb128({48'd0, r.gen});
    append_leb128(r.detail);
    expected_bytes[$].last = 1'b1;
  endtask

  function automatic logic [63:0] rand_sized(input int width);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (width < 64) v = v & ((64'd1 << width) - 64'd1);
    return v >> $urandom_range(0, width);
  endfunction

  function automatic trace_rec_t make_rec(input logic first, input logic [7:0] kind,
                                          input logic [7:0] source,
                                          input logic [63:0] stamp,
                                          input logic [15:0] loop_val,
                                          input logic [31:0] lid, input logic [15:0] gen,
                                          input logic [63:0] detail);
    trace_rec_t r;
    r.first    = first;
    r.kind     = kind;
    r.source   = source;
    r.stamp    = stamp;
    r.loop_val = loop_val;
    r.lid      = lid;
    r.gen      = gen;
    r.detail   = detail;
    return r;
  endfunction

  function automatic trace_rec_t make_random_rec();
    trace_rec_t  r;
    logic [63:0] dec;
    int          mode;
    mode       = $urandom_range(0, 99);
    r.first    = 1'b0;
    r.kind     = 8'($urandom);
    r.source   = 8'($urandom);
    r.loop_val = 16'(rand_sized(16));
    r.lid      = 32'(rand_sized(32));
    r.gen      = 16'(rand_sized(16));
    r.detail   = rand_sized(64);
    if (mode < 8) begin
      r.first = 1'b1;
      r.stamp = rand_sized(64);
    end else if (mode < 16) begin
      dec = rand_sized(64);
      if (dec > last_sent_stamp) dec = last_sent_stamp;
      r.stamp = last_sent_stamp - dec;
    end else if (mode < 22) begin
      r.stamp = last_sent_stamp;
    end else if (mode < 26) begin
      r.stamp = {$urandom, $urandom};
    end else begin
      r.stamp = last_sent_stamp + rand_sized($urandom_range(1, 64));
    end
    return r;
  endfunction

  task automatic send_record(input trace_rec_t r);
    while (idle_enable && $urandom_range(0, 99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    first_record <= r.first;
    event_kind   <= r.kind;
    event_source <= r.source;
    timestamp_ns <= r.stamp;
    loop_id      <= r.loop_val;
    proc_id      <= r.lid;
    generation   <= r.gen;
    detail_word  <= r.detail;
    do @(posedge clk); while (full);
    last_sent_stamp = r.stamp;
    encode_record(r);
  endtask

  task automatic wait_results_drained();
    push <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
  endtask

  task automatic test_field_extremes();
    send_record(make_rec(1'b0, 8'hFF, 8'hFF, '1, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, '1));
    send_record(make_rec(1'b0, 8'h00, 8'h00, '0, 16'h0000, 32'h0, 16'h0000, '0));
    send_record(make_rec(1'b1, 8'h5A, 8'hA5, '1, 16'h1234, 32'h89AB_CDEF, 16'h4321,
                         64'h0123_4567_89AB_CDEF));
  endtask

  task automatic test_first_and_backward_time();
    send_record(make_rec(1'b1, 8'h01, 8'h02, 64'd1000, 16'd1, 32'd2, 16'd3, 64'd4));
    send_record(make_rec(1'b0, 8'h03, 8'h04, 64'd1300, 16'd5, 32'd6, 16'd7, 64'd8));
    send_record(make_rec(1'b0, 8'h05, 8'h06, 64'd1300, 16'd9, 32'd10, 16'd11, 64'd12));
    send_record(make_rec(1'b0, 8'h07, 8'h08, 64'd900, 16'd13, 32'd14, 16'd15, 64'd16));
    send_record(make_rec(1'b1, 8'h09, 8'h0A, 64'd5000, 16'd17, 32'd18, 16'd19, 64'd20));
    send_record(make_rec(1'b0, 8'h0B, 8'h0C, 64'd5000 + 64'h8000_0000_0000_0000,
                         16'd21, 32'd22, 16'd23, 64'd24));
  endtask

  task automatic test_varint_boundaries();
    int          shifts[4] = '{7, 14, 28, 63};
    logic [63:0] v;
    send_record(make_rec(1'b1, 8'h10, 8'h11, 64'd0, 16'd0, 32'd0, 16'd0, 64'd0));
    foreach (shifts[i]) begin
      for (int up = 0; up < 2; up++) begin
        v = (64'd1 << shifts[i]) - ((up == 0) ? 64'd1 : 64'd0);
        send_record(make_rec(1'b0, v[7:0], v[15:8], last_sent_stamp + v, v[15:0],
                             v[31:0], v[15:0], v));
      end
    end
  endtask

  task automatic test_full_stall();
    rx_hold_request = 400;
    repeat (12) send_record(make_random_rec());
    wait_results_drained();
  endtask

  task automatic test_drain_pause();
    repeat (10) send_record(make_random_rec());
    wait_results_drained();
    repeat (10) send_record(make_random_rec());
    wait_results_drained();
  endtask

  task automatic test_random_records(input int count, input bit with_idle);
    idle_enable = with_idle;
    repeat (count) send_record(make_random_rec());
    idle_enable = 1'b1;
  endtask

  initial begin : result_sink
    enc_byte_t want;
    int        hold_left;
    pop       = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h last %0b", out_byte, last_byte));
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.value)
            report_mismatch($sformatf("out_byte %02h expected %02h", out_byte, want.value));
          if (last_byte !== want.last)
            report_mismatch($sformatf("last_byte %0b expected %0b", last_byte, want.last));
        end
        byte_count++;
      end
      if (rx_hold_request != 0) begin
        hold_left       = rx_hold_request;
        rx_hold_request = 0;
      end
      if (rst || hold_left > 0) begin
        pop <= 1'b0;
        if (hold_left > 0) hold_left--;
      end else begin
        pop <= !idle_enable || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin : cycle_watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL trace_record_varint_encoder_core");
    $finish;
  end

  initial begin
    rst             = 1'b1;
    push            = 1'b0;
    first_record    = 1'b0;
    event_kind      = '0;
    event_source    = '0;
    timestamp_ns    = '0;
    loop_id         = '0;
    proc_id         = '0;
    generation      = '0;
    detail_word     = '0;
    prev_stamp      = '0;
    last_sent_stamp = '0;
    idle_enable     = 1'b1;
    rx_hold_request = 0;
    error_count     = 0;
    byte_count      = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_field_extremes();
    test_first_and_backward_time();
    test_varint_boundaries();
    test_full_stall();
    test_drain_pause();
    test_random_records(220, 1'b1);
    test_random_records(100, 1'b0);

    wait_results_drained();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS trace_record_varint_encoder_core");
    end else begin
      $display("FAIL trace_record_varint_encoder_core");
    end
    $finish;
  end

endmodule
